/* hw/rtl/mbb_pkg.sv */
package mbb_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned ROW_OUT_W  = 10;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned IDX_W      = 2;

  typedef logic [SIZE_W-1:0]    size_t;
  typedef logic [BYTE_W-1:0]    pix_byte_t;
  typedef logic [ROW_OUT_W-1:0] row_out_t;
  typedef logic [IDX_W-1:0]     reg_idx_t;
  typedef logic [2:0]           bit_pos_t;

  localparam reg_idx_t REG_IMAGE_WIDTH  = IDX_W'(0);
  localparam reg_idx_t REG_IMAGE_HEIGHT = IDX_W'(1);

  localparam size_t RESET_WIDTH  = SIZE_W'(1024);
  localparam size_t RESET_HEIGHT = SIZE_W'(1024);
  localparam size_t LIMIT_WIDTH  = SIZE_W'(MAX_WIDTH);
  localparam size_t LIMIT_HEIGHT = SIZE_W'(MAX_HEIGHT);
  localparam size_t BYTE_STEP    = SIZE_W'(BYTE_W);

  typedef struct packed {
    logic step;
    logic restart;
  } trk_ctrl_t;

  typedef struct packed {
    size_t    box_x;
    row_out_t box_y;
    size_t    box_width;
    row_out_t box_height;
    logic     box_found;
  } box_t;

  function automatic size_t clamp_size(size_t v, size_t hi);
    size_t r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Highest set bit, which is the leftmost opaque pixel of the byte.
  function automatic bit_pos_t msb_pos(pix_byte_t b);
    bit_pos_t p;
    p = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      if (b[k]) begin
        p = bit_pos_t'(k);
      end
    end
    return p;
  endfunction

  // Lowest set bit, which is the rightmost opaque pixel of the byte.
  function automatic bit_pos_t lsb_pos(pix_byte_t b);
    bit_pos_t p;
    p = '1;
    for (int k = BYTE_W - 1; k >= 0; k--) begin
      if (b[k]) begin
        p = bit_pos_t'(k);
      end
    end
    return p;
  endfunction

endpackage

/* hw/rtl/mbb_cfg_if.sv */
interface mbb_cfg_if import mbb_pkg::*; ();
  logic     valid;
  logic     ready;
  reg_idx_t index;
  size_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/mbb_in_if.sv */
interface mbb_in_if import mbb_pkg::*; ();
  logic      valid;
  logic      ready;
  pix_byte_t mask_byte;
  logic      last_byte;

  modport source (output valid, output mask_byte, output last_byte, input ready);
  modport sink (input valid, input mask_byte, input last_byte, output ready);
endinterface

/* hw/rtl/mbb_out_if.sv */
interface mbb_out_if import mbb_pkg::*; ();
  logic     valid;
  logic     ready;
  size_t    box_x;
  row_out_t box_y;
  size_t    box_width;
  row_out_t box_height;
  logic     box_found;

  modport source (
    output valid, output box_x, output box_y, output box_width,
    output box_height, output box_found, input ready
  );
  modport sink (
    input valid, input box_x, input box_y, input box_width,
    input box_height, input box_found, output ready
  );
endinterface

/* hw/rtl/mbb_track.sv */
module mbb_track import mbb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  trk_ctrl_t ctrl,
  input  pix_byte_t mask_byte,
  input  size_t     width_eff,
  input  size_t     height_eff,
  output box_t      box_next
);

  size_t column_pos;
  size_t row_pos;
  size_t left_min;
  size_t top_min;
  size_t right_max;
  size_t bottom_max;

  size_t column_pos_next;
  size_t row_pos_next;
  size_t left_min_next;
  size_t top_min_next;
  size_t right_max_next;
  size_t bottom_max_next;

  logic     in_image;
  logic     hit;
  logic     wrap;
  bit_pos_t left_off;
  bit_pos_t right_off;
  size_t    xl;
  size_t    xr;
  size_t    col_sum;
  logic     found;

  always_comb begin
    in_image  = row_pos < height_eff;
    hit       = in_image && (mask_byte != '0);
    left_off  = ~msb_pos(mask_byte);
    right_off = ~lsb_pos(mask_byte);
    xl        = column_pos + size_t'(left_off);
    xr        = column_pos + size_t'(right_off);
    col_sum   = column_pos + BYTE_STEP;
    wrap      = col_sum >= width_eff;

    left_min_next   = (hit && xl < left_min) ? xl : left_min;
    right_max_next  = (hit && xr > right_max) ? xr : right_max;
    top_min_next    = (hit && row_pos < top_min) ? row_pos : top_min;
    bottom_max_next = (hit && row_pos > bottom_max) ? row_pos : bottom_max;

    column_pos_next = column_pos;
    row_pos_next    = row_pos;
    if (in_image) begin
      if (wrap) begin
        column_pos_next = '0;
        row_pos_next    = row_pos + SIZE_W'(1);
      end else begin
        column_pos_next = col_sum;
      end
    end

    found = (left_min_next <= right_max_next) && (top_min_next <= bottom_max_next);
    if (found) begin
      box_next.box_x      = left_min_next;
      box_next.box_y      = top_min_next[ROW_OUT_W-1:0];
      box_next.box_width  = right_max_next - left_min_next;
      box_next.box_height = row_out_t'(bottom_max_next - top_min_next);
      box_next.box_found  = 1'b1;
    end else begin
      box_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
      left_min   <= RESET_WIDTH;
      top_min    <= RESET_HEIGHT;
      right_max  <= '0;
      bottom_max <= '0;
    end else if (ctrl.restart) begin
      column_pos <= '0;
      row_pos    <= '0;
      left_min   <= width_eff;
      top_min    <= height_eff;
      right_max  <= '0;
      bottom_max <= '0;
    end else if (ctrl.step) begin
      column_pos <= column_pos_next;
      row_pos    <= row_pos_next;
      left_min   <= left_min_next;
      top_min    <= top_min_next;
      right_max  <= right_max_next;
      bottom_max <= bottom_max_next;
    end
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    ctrl.restart || column_pos < width_eff)
    else $error("Column position is outside the row.");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl.restart || row_pos <= height_eff)
    else $error("Row position passed the image height.");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    ctrl.restart |=> column_pos == '0 && row_pos == '0 && right_max == '0 &&
                     bottom_max == '0)
    else $error("Scan state not cleared after restart.");

endmodule

/* hw/rtl/mask_bitmap_bounding_box_core.sv */
// Channel  Dir  Fields                                          Transaction when
// cfg      in   index, data                                     cfg.valid && cfg.ready
// in_ch    in   mask_byte, last_byte                            in_ch.valid && in_ch.ready
// out_ch   out  box_x, box_y, box_width, box_height, box_found  out_ch.valid && out_ch.ready
//
// One mask byte per cycle unless stalled; a last byte goes to s1, its result then to out_box.
// The byte register feeds the scan state update, a pair of priority encoders and 11-bit adds.
// Reset is synchronous and restores both size registers to 1024 and clears the scan.
// in_ch stalls only when a last byte waits behind an output result that is not yet taken.
module mask_bitmap_bounding_box_core import mbb_pkg::*; (
  input logic        clk,
  input logic        rst,
  mbb_cfg_if.sink    cfg,
  mbb_in_if.sink     in_ch,
  mbb_out_if.source  out_ch
);

  size_t     image_width;
  size_t     image_height;
  logic      s1_valid;
  pix_byte_t s1_byte;
  logic      s1_last;
  logic      out_valid;
  box_t      out_box;

  logic      cfg_write;
  logic      wr_width;
  logic      wr_height;
  size_t     width_sel;
  size_t     height_sel;
  size_t     width_eff;
  size_t     height_eff;
  logic      stall;
  logic      advance;
  logic      out_load;
  trk_ctrl_t trk_ctrl;
  box_t      box_next;

  always_comb begin
    cfg_write  = cfg.valid && cfg.ready;
    wr_width   = cfg_write && (cfg.index == REG_IMAGE_WIDTH);
    wr_height  = cfg_write && (cfg.index == REG_IMAGE_HEIGHT);
    width_sel  = wr_width ? cfg.data : image_width;
    height_sel = wr_height ? cfg.data : image_height;
    width_eff  = clamp_size(width_sel, LIMIT_WIDTH);
    height_eff = clamp_size(height_sel, LIMIT_HEIGHT);

    stall    = s1_valid && s1_last && out_valid && !out_ch.ready;
    advance  = s1_valid && !stall;
    out_load = advance && s1_last;

    trk_ctrl.step    = advance;
    trk_ctrl.restart = out_load || wr_width || wr_height;
  end

  assign cfg.ready   = 1'b1;
  assign in_ch.ready = !stall;

  mbb_track u_track (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (trk_ctrl),
    .mask_byte  (s1_byte),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .box_next   (box_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (wr_width) begin
        image_width <= cfg.data;
      end
      if (wr_height) begin
        image_height <= cfg.data;
      end
      if (in_ch.ready) begin
        s1_valid <= in_ch.valid;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte <= in_ch.mask_byte;
      s1_last <= in_ch.last_byte;
    end
    if (out_load) begin
      out_box <= box_next;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.box_x      = out_box.box_x;
  assign out_ch.box_y      = out_box.box_y;
  assign out_ch.box_width  = out_box.box_width;
  assign out_ch.box_height = out_box.box_height;
  assign out_ch.box_found  = out_box.box_found;

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_last))
    else $error("Result raised without a last byte in the byte register.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    stall |=> s1_valid && s1_last && $stable(s1_byte))
    else $error("Byte register changed while stalled.");

  a_empty_box: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_box.box_found |-> out_box.box_x == '0 && out_box.box_width == '0)
    else $error("Empty result carries a nonzero box.");

endmodule
